### src/rcd_pkg.sv
// Shared types and constants for the residual change detector.
// No dependencies; rcd_datapath, rcd_ctrl and the top refer to it by scoped names.
package rcd_pkg;

  // Detection modes
  localparam logic [1:0] MODE_THRESHOLD = 2'd0;
  localparam logic [1:0] MODE_EWMA      = 2'd1;
  localparam logic [1:0] MODE_CUSUM     = 2'd2;
  localparam logic [1:0] MODE_UNUSED    = 2'd3;

  // Configuration register indexes
  localparam int          CFG_IDX_W       = 4;
  localparam logic [3:0]  REG_MODE        = 4'd0;
  localparam logic [3:0]  REG_ALPHA       = 4'd1;
  localparam logic [3:0]  REG_FAN_THR     = 4'd2;
  localparam logic [3:0]  REG_PUMP_THR    = 4'd3;
  localparam logic [3:0]  REG_SENSOR_THR  = 4'd4;
  localparam logic [3:0]  REG_FAN_CUS     = 4'd5;
  localparam logic [3:0]  REG_PUMP_CUS    = 4'd6;
  localparam logic [3:0]  REG_SENSOR_CUS  = 4'd7;

  // Register reset values
  localparam logic [1:0]  RST_MODE        = MODE_THRESHOLD;
  localparam logic [15:0] RST_ALPHA       = 16'd13107;
  localparam logic [15:0] RST_FAN_THR     = 16'd16384;
  localparam logic [15:0] RST_PUMP_THR    = 16'd13107;
  localparam logic [15:0] RST_SENSOR_THR  = 16'd512;
  localparam logic [15:0] RST_FAN_CUS     = 16'd52429;
  localparam logic [15:0] RST_PUMP_CUS    = 16'd52429;
  localparam logic [15:0] RST_SENSOR_CUS  = 16'd2048;

  // CUSUM allowances: 0.05 in Q0.16 for duties, 0.25 degrees in Q8.8
  localparam logic [15:0] DUTY_ALLOW      = 16'd3277;
  localparam logic [15:0] SENSOR_ALLOW    = 16'd64;

  // Channel codes
  localparam logic [1:0]  CH_FAN          = 2'd0;
  localparam logic [1:0]  CH_PUMP         = 2'd1;
  localparam logic [1:0]  CH_SENSOR       = 2'd2;

  // Stream widths
  localparam int          IN_TDATA_W      = 104;
  localparam int          OUT_TDATA_W     = 24;

  // Controller to datapath commands
  typedef struct packed {
    logic       load_in;
    logic       mul_en;
    logic       upd_en;
    logic       div_start;
    logic       fold_en;
    logic       fold_first;
    logic       out_load;
    logic [1:0] ch;
  } rcd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic out_full;
  } rcd_status_t;

endpackage

### src/rcd_div.sv
// Shared restoring divider: 16-bit saturated quotient of (value * 256) / divisor.
// Depends on nothing beyond its parameter; used by rcd_datapath.
module rcd_div #(
  parameter int VAL_W = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [VAL_W-1:0] value_i,
  input  logic [15:0]      divisor_i,
  output logic             done_o,
  output logic [15:0]      quot_o
);

  localparam int CMP_W = (VAL_W > 24) ? VAL_W : 24;
  localparam int STEPS = 16;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]      rem_q, rem_d;
  logic [15:0]      num_q, num_d;
  logic [15:0]      quot_q, quot_d;
  logic [15:0]      dsr_q, dsr_d;
  logic [CMP_W-1:0] val_ext;
  logic [CMP_W-1:0] lim_ext;
  logic [16:0]      trial;
  logic [16:0]      trial_sub;
  logic             fits;

  // Quotient overflows 16 bits exactly when value >= divisor * 256
  assign val_ext   = CMP_W'(value_i);
  assign lim_ext   = CMP_W'({divisor_i, 8'h00});
  assign trial     = {rem_q, num_q[15]};
  assign fits      = (trial >= {1'b0, dsr_q});
  assign trial_sub = trial - {1'b0, dsr_q};

  // Start, saturate early, or take one quotient bit per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    quot_d = quot_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      if (divisor_i == 16'd0) begin
        quot_d = (value_i != '0) ? 16'hFFFF : 16'h0000;
        done_d = 1'b1;
        busy_d = 1'b0;
      end else if (val_ext >= lim_ext) begin
        quot_d = 16'hFFFF;
        done_d = 1'b1;
        busy_d = 1'b0;
      end else begin
        busy_d = 1'b1;
        cnt_d  = '0;
        rem_d  = val_ext[23:8];
        num_d  = {val_ext[7:0], 8'h00};
        dsr_d  = divisor_i;
        quot_d = 16'h0000;
      end
    end else if (busy_q) begin
      rem_d  = fits ? trial_sub[15:0] : trial[15:0];
      num_d  = {num_q[14:0], 1'b0};
      quot_d = {quot_q[14:0], fits};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    num_q  <= num_d;
    quot_q <= quot_d;
    dsr_q  <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### src/rcd_datapath.sv
// Datapath: configuration registers, residuals, EWMA/CUSUM state, divider,
// maximum search and output register. Depends on rcd_pkg and rcd_div.
module rcd_datapath #(
  parameter int SUM_WIDTH = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [3:0]             cfg_index_i,
  input  logic [15:0]            cfg_data_i,
  input  logic [15:0]            fan_demand_i,
  input  logic [15:0]            fan_feedback_i,
  input  logic [15:0]            pump_demand_i,
  input  logic [15:0]            pump_feedback_i,
  input  logic signed [16:0]     coolant_measured_i,
  input  logic signed [16:0]     coolant_reference_i,
  input  rcd_pkg::rcd_cmd_t      cmd_i,
  output rcd_pkg::rcd_status_t   status_o,
  input  logic                   m_tready_i,
  output logic                   m_tvalid_o,
  output logic [15:0]            score_o,
  output logic [1:0]             source_channel_o,
  output logic                   alarm_o
);

  // Configuration registers
  logic [1:0]  mode_q;
  logic [15:0] alpha_q;
  logic [15:0] fan_thr_q, pump_thr_q, sensor_thr_q;
  logic [15:0] fan_cus_q, pump_cus_q, sensor_cus_q;

  // Residuals of the current sample
  logic [15:0] res_fan_q, res_pump_q;
  logic [16:0] res_sensor_q;
  logic [15:0] res_fan_d, res_pump_d;
  logic [16:0] res_sensor_d;
  logic signed [17:0] sensor_diff;

  // Detector state
  logic [15:0]          smooth_fan_q, smooth_pump_q, smooth_sensor_q;
  logic [SUM_WIDTH-1:0] sum_fan_q, sum_pump_q, sum_sensor_q;

  // Per-channel selection
  logic [16:0]          res_sel;
  logic [15:0]          res_sat;
  logic [15:0]          smooth_sel;
  logic [SUM_WIDTH-1:0] sum_sel;
  logic [15:0]          thr_sel;
  logic [15:0]          cus_sel;
  logic [15:0]          allow_sel;

  // EWMA arithmetic
  logic signed [16:0] ewma_diff;
  logic signed [33:0] prod_d, prod_q;
  logic signed [34:0] ewma_acc;
  logic [15:0]        ewma_new;

  // CUSUM arithmetic
  logic [SUM_WIDTH:0]   cus_sum, cus_sub, allow_ext;
  logic [SUM_WIDTH-1:0] cus_new;

  // Divider and result
  logic [SUM_WIDTH-1:0] div_val;
  logic [15:0]          div_dsr;
  logic                 div_done;
  logic [15:0]          div_quot;
  logic [15:0]          best_q;
  logic [1:0]           best_ch_q;
  logic                 m_tvalid_q;
  logic [15:0]          score_q;
  logic [1:0]           source_q;
  logic                 alarm_q;

  // Write configuration registers, masked to their widths
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= rcd_pkg::RST_MODE;
      alpha_q      <= rcd_pkg::RST_ALPHA;
      fan_thr_q    <= rcd_pkg::RST_FAN_THR;
      pump_thr_q   <= rcd_pkg::RST_PUMP_THR;
      sensor_thr_q <= rcd_pkg::RST_SENSOR_THR;
      fan_cus_q    <= rcd_pkg::RST_FAN_CUS;
      pump_cus_q   <= rcd_pkg::RST_PUMP_CUS;
      sensor_cus_q <= rcd_pkg::RST_SENSOR_CUS;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rcd_pkg::REG_MODE:       mode_q       <= cfg_data_i[1:0];
        rcd_pkg::REG_ALPHA:      alpha_q      <= cfg_data_i;
        rcd_pkg::REG_FAN_THR:    fan_thr_q    <= cfg_data_i;
        rcd_pkg::REG_PUMP_THR:   pump_thr_q   <= cfg_data_i;
        rcd_pkg::REG_SENSOR_THR: sensor_thr_q <= cfg_data_i;
        rcd_pkg::REG_FAN_CUS:    fan_cus_q    <= cfg_data_i;
        rcd_pkg::REG_PUMP_CUS:   pump_cus_q   <= cfg_data_i;
        rcd_pkg::REG_SENSOR_CUS: sensor_cus_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Form absolute residuals from the incoming beat
  assign sensor_diff  = {coolant_measured_i[16], coolant_measured_i}
                      - {coolant_reference_i[16], coolant_reference_i};
  assign res_fan_d    = (fan_demand_i >= fan_feedback_i) ? fan_demand_i - fan_feedback_i
                                                         : fan_feedback_i - fan_demand_i;
  assign res_pump_d   = (pump_demand_i >= pump_feedback_i) ? pump_demand_i - pump_feedback_i
                                                           : pump_feedback_i - pump_demand_i;
  assign res_sensor_d = sensor_diff[17] ? 17'(-sensor_diff) : sensor_diff[16:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      res_fan_q    <= res_fan_d;
      res_pump_q   <= res_pump_d;
      res_sensor_q <= res_sensor_d;
    end
  end

  // Select the channel under work
  always_comb begin
    case (cmd_i.ch)
      rcd_pkg::CH_PUMP: begin
        res_sel    = {1'b0, res_pump_q};
        smooth_sel = smooth_pump_q;
        sum_sel    = sum_pump_q;
        thr_sel    = pump_thr_q;
        cus_sel    = pump_cus_q;
        allow_sel  = rcd_pkg::DUTY_ALLOW;
      end
      rcd_pkg::CH_SENSOR: begin
        res_sel    = res_sensor_q;
        smooth_sel = smooth_sensor_q;
        sum_sel    = sum_sensor_q;
        thr_sel    = sensor_thr_q;
        cus_sel    = sensor_cus_q;
        allow_sel  = rcd_pkg::SENSOR_ALLOW;
      end
      default: begin
        res_sel    = {1'b0, res_fan_q};
        smooth_sel = smooth_fan_q;
        sum_sel    = sum_fan_q;
        thr_sel    = fan_thr_q;
        cus_sel    = fan_cus_q;
        allow_sel  = rcd_pkg::DUTY_ALLOW;
      end
    endcase
  end

  // EWMA: s + alpha * (r - s), rounded; the sensor residual saturates to 16 bits
  assign res_sat   = res_sel[16] ? 16'hFFFF : res_sel[15:0];
  assign ewma_diff = $signed({1'b0, res_sat}) - $signed({1'b0, smooth_sel});
  assign prod_d    = $signed({1'b0, alpha_q}) * ewma_diff;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  assign ewma_acc = $signed({3'b000, smooth_sel, 16'h0000}) + 35'(prod_q)
                  + 35'sd32768;
  assign ewma_new = ewma_acc[31:16];

  // CUSUM: add residual, take off the allowance, floor at zero, saturate
  assign allow_ext = (SUM_WIDTH + 1)'(allow_sel);
  assign cus_sum   = {1'b0, sum_sel} + (SUM_WIDTH + 1)'(res_sel);
  assign cus_sub   = (cus_sum > allow_ext) ? cus_sum - allow_ext : '0;
  assign cus_new   = cus_sub[SUM_WIDTH] ? '1 : cus_sub[SUM_WIDTH-1:0];

  // Update the state of the active mode only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_fan_q    <= '0;
      smooth_pump_q   <= '0;
      smooth_sensor_q <= '0;
      sum_fan_q       <= '0;
      sum_pump_q      <= '0;
      sum_sensor_q    <= '0;
    end else if (cmd_i.upd_en) begin
      if (mode_q == rcd_pkg::MODE_EWMA) begin
        case (cmd_i.ch)
          rcd_pkg::CH_FAN:    smooth_fan_q    <= ewma_new;
          rcd_pkg::CH_PUMP:   smooth_pump_q   <= ewma_new;
          rcd_pkg::CH_SENSOR: smooth_sensor_q <= ewma_new;
          default: ;
        endcase
      end else if (mode_q == rcd_pkg::MODE_CUSUM) begin
        case (cmd_i.ch)
          rcd_pkg::CH_FAN:    sum_fan_q    <= cus_new;
          rcd_pkg::CH_PUMP:   sum_pump_q   <= cus_new;
          rcd_pkg::CH_SENSOR: sum_sensor_q <= cus_new;
          default: ;
        endcase
      end
    end
  end

  // Pick the value and divisor for normalization
  always_comb begin
    if (mode_q == rcd_pkg::MODE_CUSUM) begin
      div_val = sum_sel;
      div_dsr = cus_sel;
    end else if (mode_q == rcd_pkg::MODE_EWMA) begin
      div_val = SUM_WIDTH'(smooth_sel);
      div_dsr = thr_sel;
    end else begin
      div_val = SUM_WIDTH'(res_sel);
      div_dsr = thr_sel;
    end
  end

  rcd_div #(
    .VAL_W (SUM_WIDTH)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .value_i   (div_val),
    .divisor_i (div_dsr),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // Keep the largest score; ties keep the earlier channel
  always_ff @(posedge clk_i) begin
    if (cmd_i.fold_en && (cmd_i.fold_first || (div_quot > best_q))) begin
      best_q    <= div_quot;
      best_ch_q <= cmd_i.ch;
    end
  end

  // Output register: load a result, drop valid once the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (mode_q == rcd_pkg::MODE_UNUSED) begin
        score_q  <= 16'h0000;
        source_q <= rcd_pkg::CH_FAN;
        alarm_q  <= 1'b0;
      end else begin
        score_q  <= best_q;
        source_q <= best_ch_q;
        alarm_q  <= (best_q[15:8] != 8'h00);
      end
    end
  end

  assign status_o.div_done = div_done;
  assign status_o.out_full = m_tvalid_q && !m_tready_i;
  assign m_tvalid_o        = m_tvalid_q;
  assign score_o           = score_q;
  assign source_channel_o  = source_q;
  assign alarm_o           = alarm_q;

  // A result never overwrites one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(m_tvalid_q && !m_tready_i))
    else $error("result loaded while output beat stalled");

  // A score is folded only when the divider has finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fold_en |-> div_done)
    else $error("score folded before divider done");

  // The unused mode reports a quiet result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && (mode_q == rcd_pkg::MODE_UNUSED))
      |=> (score_q == 16'h0000) && !alarm_q)
    else $error("unused mode gave a nonzero result");

  // Threshold mode leaves the fan EWMA and sensor CUSUM state untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(mode_q) == rcd_pkg::MODE_THRESHOLD) |->
      ($stable(smooth_fan_q) && $stable(sum_sensor_q)))
    else $error("detector state changed in threshold mode");

endmodule

### src/rcd_ctrl.sv
// Controller: sequences residual load, state update, division and fold per channel, then the output load.
// Depends on rcd_pkg for the command and status structs and channel codes.
module rcd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  rcd_pkg::rcd_status_t status_i,
  output rcd_pkg::rcd_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [1:0] ch_q, ch_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    ch_d       = ch_q;
    s_tready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.ch   = ch_q;
    unique case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load_in = 1'b1;
          ch_d          = rcd_pkg::CH_FAN;
          state_d       = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd_en = 1'b1;
        state_d      = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_WAIT;
      end
      S_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.fold_en    = 1'b1;
          cmd_o.fold_first = (ch_q == rcd_pkg::CH_FAN);
          if (ch_q == rcd_pkg::CH_SENSOR) begin
            state_d = S_OUT;
          end else begin
            ch_d    = ch_q + 2'd1;
            state_d = S_MUL;
          end
        end
      end
      S_OUT: begin
        if (!status_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ch_q    <= rcd_pkg::CH_FAN;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
    end
  end

endmodule

### src/residual_change_detector_top.sv
// Residual change detector: scores fan, pump and coolant sensor residuals and
// raises an alarm at a normalized score of 1.0 or more. The three channels of
// an item go one after another through a single state update and a shared
// 16-step restoring divider, which finishes early when the score saturates or
// the divisor is zero. A new input beat is taken as soon as the result has
// moved into the output register, while that result still waits.
// Configuration writes are always accepted; write them only between items.
// Depends on rcd_pkg, rcd_ctrl, rcd_datapath and rcd_div.
module residual_change_detector_top #(
  parameter int SUM_WIDTH = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rcd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [15:0]                      cfg_data_i,
  // Sample input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // fan_demand[15:0], fan_feedback[31:16], pump_demand[47:32],
  // pump_feedback[63:48], coolant_measured[80:64], coolant_reference[97:81]
  input  logic [rcd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // Result output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // score[15:0], source_channel[17:16], alarm[18]
  output logic [rcd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  rcd_pkg::rcd_cmd_t    cmd;
  rcd_pkg::rcd_status_t status;
  logic [15:0]          score;
  logic [1:0]           source_channel;
  logic                 alarm;

  assign cfg_ready_o = 1'b1;

  rcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rcd_datapath #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .fan_demand_i        (s_axis_tdata[15:0]),
    .fan_feedback_i      (s_axis_tdata[31:16]),
    .pump_demand_i       (s_axis_tdata[47:32]),
    .pump_feedback_i     (s_axis_tdata[63:48]),
    .coolant_measured_i  (s_axis_tdata[80:64]),
    .coolant_reference_i (s_axis_tdata[97:81]),
    .cmd_i               (cmd),
    .status_o            (status),
    .m_tready_i          (m_axis_tready),
    .m_tvalid_o          (m_axis_tvalid),
    .score_o             (score),
    .source_channel_o    (source_channel),
    .alarm_o             (alarm)
  );

  // Pack the result beat, low field first
  assign m_axis_tdata = {5'b00000, alarm, source_channel, score};

endmodule

### sim/tb_residual_change_detector_top.sv
// Self-checking bench for residual_change_detector_top: scores every sample beat
// against a behavioral detector model that keeps its own register and filter state.
// Depends on rcd_pkg and the RTL in src; no files or arguments are read.
`timescale 1ns / 100ps

module tb_residual_change_detector_top;
  import rcd_pkg::*;

  localparam int SUM_W = 24;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  // Indexes past the register map; each would alias a live register if decoded short
  localparam logic [3:0] IDX_ALIAS_MODE   = 4'd8;
  localparam logic [3:0] IDX_ALIAS_SENSOR = 4'd12;

  // One sample, packed so that fan_demand lands in the lowest bits
  typedef struct packed {
    logic [16:0] coolant_reference;
    logic [16:0] coolant_measured;
    logic [15:0] pump_feedback;
    logic [15:0] pump_demand;
    logic [15:0] fan_feedback;
    logic [15:0] fan_demand;
  } sample_t;

  typedef struct packed {
    logic        alarm;
    logic [1:0]  source_channel;
    logic [15:0] score;
  } score_beat_t;

  typedef enum {PROF_MIXED, PROF_RAIL, PROF_STEADY} sample_profile_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Detector model: registers and filter state
  logic [1:0]       mode_reg;
  logic [15:0]      alpha_reg;
  logic [15:0]      thr_reg [3];
  logic [15:0]      cus_reg [3];
  logic [15:0]      smooth_val [3];
  logic [SUM_W-1:0] cusum_val [3];

  sample_t     sample_q [$];
  score_beat_t score_q [$];
  sample_t     drive_sample;
  int          samples_pending = 0;
  int          send_gap = 0;
  int          stall_left = 0;
  bit          calm_tail = 1'b0;
  int          mismatches = 0;
  int          beats_checked = 0;
  int          alarms_seen = 0;
  int          mode_count [4] = '{0, 0, 0, 0};
  int          cycle_count = 0;

  residual_change_detector_top #(
    .SUM_WIDTH(SUM_W)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Score = floor(value * 256 / divisor), saturated; zero divisor flags any nonzero value
  function automatic logic [15:0] normalize(logic [31:0] value, logic [15:0] divisor);
    logic [39:0] quot;
    if (divisor == '0) return (value != '0) ? 16'hFFFF : 16'h0000;
    quot = {value, 8'h00} / divisor;
    return (quot > 40'hFFFF) ? 16'hFFFF : quot[15:0];
  endfunction

  // Advance the detector model by one sample and return the score beat it produces
  function automatic score_beat_t detect_change(sample_t smp);
    logic [16:0] resid [3];
    logic [15:0] chan_score [3];
    logic [16:0] clipped;
    logic [39:0] acc;
    logic [15:0] allow;
    int          diff;
    score_beat_t res;
    resid[CH_FAN] = (smp.fan_demand >= smp.fan_feedback) ?
                    17'(smp.fan_demand - smp.fan_feedback) :
                    17'(smp.fan_feedback - smp.fan_demand);
    resid[CH_PUMP] = (smp.pump_demand >= smp.pump_feedback) ?
                     17'(smp.pump_demand - smp.pump_feedback) :
                     17'(smp.pump_feedback - smp.pump_demand);
    diff = int'($signed(smp.coolant_measured)) - int'($signed(smp.coolant_reference));
    resid[CH_SENSOR] = 17'((diff < 0) ? -diff : diff);
    mode_count[mode_reg]++;
    res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      case (mode_reg)
        MODE_THRESHOLD: begin
          chan_score[ch] = normalize(32'(resid[ch]), thr_reg[ch]);
        end
        MODE_EWMA: begin
          clipped = (resid[ch] > 17'd65535) ? 17'd65535 : resid[ch];
          acc = 40'(alpha_reg) * clipped + (40'd65536 - alpha_reg) * smooth_val[ch]
                + 40'd32768;
          smooth_val[ch] = acc[31:16];
          chan_score[ch] = normalize(32'(smooth_val[ch]), thr_reg[ch]);
        end
        MODE_CUSUM: begin
          allow = (ch == CH_SENSOR) ? SENSOR_ALLOW : DUTY_ALLOW;
          acc = 40'(cusum_val[ch]) + resid[ch];
          acc = (acc > allow) ? acc - allow : 40'd0;
          cusum_val[ch] = (acc > SUM_MAX) ? SUM_MAX : acc[SUM_W-1:0];
          chan_score[ch] = normalize(32'(cusum_val[ch]), cus_reg[ch]);
        end
        default: begin
          // unused mode: all-zero beat, no state change
          return res;
        end
      endcase
    end
    // Ties keep the earlier channel
    res.score = chan_score[CH_FAN];
    res.source_channel = CH_FAN;
    if (chan_score[CH_PUMP] > res.score) begin
      res.score = chan_score[CH_PUMP];
      res.source_channel = CH_PUMP;
    end
    if (chan_score[CH_SENSOR] > res.score) begin
      res.score = chan_score[CH_SENSOR];
      res.source_channel = CH_SENSOR;
    end
    res.alarm = (res.score >= 16'd256);
    return res;
  endfunction

  function automatic sample_t make_sample(logic [15:0] fan_dem, logic [15:0] fan_fb,
                                          logic [15:0] pump_dem, logic [15:0] pump_fb,
                                          logic [16:0] cool_meas, logic [16:0] cool_ref);
    sample_t smp;
    smp.fan_demand = fan_dem;
    smp.fan_feedback = fan_fb;
    smp.pump_demand = pump_dem;
    smp.pump_feedback = pump_fb;
    smp.coolant_measured = cool_meas;
    smp.coolant_reference = cool_ref;
    return smp;
  endfunction

  function automatic sample_t random_sample(sample_profile_e prof);
    sample_t smp;
    int      spread;
    int      base;
    smp = $bits(sample_t)'({$urandom, $urandom, $urandom, $urandom});
    case (prof)
      PROF_RAIL: begin
        // sensor residual pinned at full scale, fan feedback the complement of fan demand
        smp.fan_feedback = ~smp.fan_demand;
        if ($urandom_range(0, 1) == 0) begin
          smp.coolant_measured = 17'h0FFFF;
          smp.coolant_reference = 17'h10000;
        end else begin
          smp.coolant_measured = 17'h10000;
          smp.coolant_reference = 17'h0FFFF;
        end
      end
      PROF_STEADY: begin
        smp.fan_feedback = smp.fan_demand;
        smp.pump_feedback = smp.pump_demand;
        smp.coolant_reference = smp.coolant_measured;
      end
      default: begin
        if ($urandom_range(0, 3) != 0) begin
          // tracking loop: feedback near command, sensor near truth
          case ($urandom_range(0, 3))
            0: spread = 32;
            1: spread = 1024;
            2: spread = 8192;
            default: spread = 30000;
          endcase
          smp.fan_feedback = smp.fan_demand
                             + 16'(int'($urandom_range(0, 2 * spread)) - spread);
          smp.pump_feedback = smp.pump_demand
                              + 16'(int'($urandom_range(0, 2 * spread)) - spread);
          base = int'($urandom_range(0, 51200)) - 10240;
          smp.coolant_measured = 17'(base);
          smp.coolant_reference = 17'(base + int'($urandom_range(0, spread / 2)) - spread / 4);
        end
      end
    endcase
    return smp;
  endfunction

  task automatic queue_sample(sample_t smp);
    sample_q.push_back(smp);
    samples_pending++;
  endtask

  task automatic queue_random(int count, sample_profile_e prof);
    for (int i = 0; i < count; i++) queue_sample(random_sample(prof));
  endtask

  // Hold until every queued sample is taken and every score beat has come back
  task automatic wait_idle();
    while (samples_pending != 0 || score_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [15:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_MODE:       mode_reg = value[1:0];
      REG_ALPHA:      alpha_reg = value;
      REG_FAN_THR:    thr_reg[CH_FAN] = value;
      REG_PUMP_THR:   thr_reg[CH_PUMP] = value;
      REG_SENSOR_THR: thr_reg[CH_SENSOR] = value;
      REG_FAN_CUS:    cus_reg[CH_FAN] = value;
      REG_PUMP_CUS:   cus_reg[CH_PUMP] = value;
      REG_SENSOR_CUS: cus_reg[CH_SENSOR] = value;
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("MISMATCH beat %0d: %s got %0d expected %0d", beats_checked, what, got, want);
  endtask

  // Sample driver: predict on each accepted beat, then load the next or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        score_q.push_back(detect_change(drive_sample));
        samples_pending--;
      end
      if (send_gap != 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (sample_q.size() != 0) begin
        drive_sample = sample_q.pop_front();
        s_axis_tdata <= {{(IN_TDATA_W - $bits(sample_t)){1'b0}}, drive_sample};
        s_axis_tvalid <= 1'b1;
        if (!calm_tail && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 4);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Score monitor: compare each accepted beat with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (score_q.size() == 0) begin
          report_mismatch("unexpected beat, score", m_axis_tdata[15:0], -1);
        end else begin
          score_beat_t want;
          score_beat_t got;
          want = score_q.pop_front();
          got = m_axis_tdata[$bits(score_beat_t)-1:0];
          if (got.score != want.score) report_mismatch("score", got.score, want.score);
          if (got.source_channel != want.source_channel)
            report_mismatch("source_channel", got.source_channel, want.source_channel);
          if (got.alarm != want.alarm) report_mismatch("alarm", got.alarm, want.alarm);
          if (got.alarm) alarms_seen++;
        end
        beats_checked++;
      end
      // Stall the output at random, except in the calm tail
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_count, score_q.size());
      $display("residual_change_detector_top regression: fail");
      $finish;
    end
  end

  initial begin
    mode_reg = RST_MODE;
    alpha_reg = RST_ALPHA;
    thr_reg[CH_FAN] = RST_FAN_THR;
    thr_reg[CH_PUMP] = RST_PUMP_THR;
    thr_reg[CH_SENSOR] = RST_SENSOR_THR;
    cus_reg[CH_FAN] = RST_FAN_CUS;
    cus_reg[CH_PUMP] = RST_PUMP_CUS;
    cus_reg[CH_SENSOR] = RST_SENSOR_CUS;
    for (int ch = 0; ch < 3; ch++) begin
      smooth_val[ch] = '0;
      cusum_val[ch] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Writes past the map must not land anywhere
    write_reg(IDX_ALIAS_MODE, {14'd0, MODE_UNUSED});
    write_reg(IDX_ALIAS_SENSOR, 16'd1);

    // Threshold mode with reset limits: rails, coolant extremes, ties, alarm edge
    queue_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 17'd0, 17'd0));
    queue_sample(make_sample(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 17'd0, 17'd0));
    queue_sample(make_sample(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 17'd0, 17'd0));
    queue_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 17'h0FFFF, 17'h10000));
    queue_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 17'h10000, 17'h0FFFF));
    queue_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 17'(40960), 17'(-10240)));
    queue_sample(make_sample(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 17'h15555, 17'h0AAAA));
    queue_sample(make_sample(16'd16384, 16'd0, 16'd13107, 16'd0, 17'd512, 17'd0));
    queue_sample(make_sample(16'd0, 16'd0, 16'd13107, 16'd0, 17'd512, 17'd0));
    queue_sample(make_sample(16'd16320, 16'd0, 16'd0, 16'd0, 17'd0, 17'd0));
    queue_sample(make_sample(16'd100, 16'd100, 16'd200, 16'd200, 17'(-300), 17'(-200)));
    wait_idle();

    // Unused mode, written with junk in the upper data bits
    write_reg(REG_MODE, {14'h3FFF, MODE_UNUSED});
    queue_sample(make_sample(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 17'h0FFFF, 17'h10000));
    queue_sample(make_sample(16'h1234, 16'h8765, 16'h0F0F, 16'hF0F0, 17'h00123, 17'h1FEDC));
    wait_idle();

    // Zero divisors, then unit divisors so the full-scale fan residual saturates
    write_reg(REG_MODE, {14'h0001, MODE_THRESHOLD});
    write_reg(REG_FAN_THR, 16'd0);
    write_reg(REG_PUMP_THR, 16'd0);
    write_reg(REG_SENSOR_THR, 16'd0);
    queue_sample(make_sample(16'd1, 16'd0, 16'd0, 16'd0, 17'd0, 17'd0));
    queue_sample(make_sample(16'd0, 16'd0, 16'd0, 16'd0, 17'd0, 17'd0));
    queue_sample(make_sample(16'd0, 16'd0, 16'd0, 16'd1, 17'd0, 17'd1));
    wait_idle();
    write_reg(REG_FAN_THR, 16'd1);
    write_reg(REG_PUMP_THR, 16'd1);
    write_reg(REG_SENSOR_THR, 16'd1);
    queue_sample(make_sample(16'hFFFF, 16'h0000, 16'd1, 16'd0, 17'd1, 17'd0));
    wait_idle();

    // EWMA with the heaviest weight on the new residual
    write_reg(REG_MODE, {14'h3FFD, MODE_EWMA});
    write_reg(REG_ALPHA, 16'hFFFF);
    queue_sample(make_sample(16'hFFFF, 16'h0000, 16'h0000, 16'h8000, 17'h0FFFF, 17'h10000));
    queue_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 17'd0, 17'd0));
    wait_idle();

    // Threshold mode, random limits
    write_reg(REG_MODE, {14'd0, MODE_THRESHOLD});
    write_reg(REG_FAN_THR, 16'($urandom_range(2000, 60000)));
    write_reg(REG_PUMP_THR, 16'($urandom_range(2000, 60000)));
    write_reg(REG_SENSOR_THR, 16'($urandom_range(64, 4096)));
    queue_random(140, PROF_MIXED);
    wait_idle();

    // EWMA, random weight
    write_reg(REG_MODE, {14'd0, MODE_EWMA});
    write_reg(REG_ALPHA, 16'($urandom_range(1000, 40000)));
    queue_random(120, PROF_MIXED);
    wait_idle();

    // CUSUM, random limits
    write_reg(REG_MODE, {14'd0, MODE_CUSUM});
    write_reg(REG_FAN_CUS, 16'($urandom_range(4000, 65535)));
    write_reg(REG_PUMP_CUS, 16'($urandom_range(4000, 65535)));
    write_reg(REG_SENSOR_CUS, 16'($urandom_range(256, 8192)));
    queue_random(100, PROF_MIXED);
    wait_idle();

    // Drive the sensor sum into saturation, then let the sums bleed down by the allowance
    write_reg(REG_FAN_CUS, 16'hFFFF);
    write_reg(REG_PUMP_CUS, 16'hFFFF);
    write_reg(REG_SENSOR_CUS, 16'hFFFF);
    queue_random(200, PROF_RAIL);
    queue_random(30, PROF_STEADY);
    wait_idle();

    // Unused mode with live data; EWMA and CUSUM state must hold
    write_reg(REG_MODE, {14'd0, MODE_UNUSED});
    queue_random(20, PROF_MIXED);
    wait_idle();

    // EWMA resumes from held state at the weight extremes
    write_reg(REG_MODE, {14'd0, MODE_EWMA});
    write_reg(REG_FAN_THR, 16'($urandom_range(1000, 30000)));
    write_reg(REG_PUMP_THR, 16'($urandom_range(1000, 30000)));
    write_reg(REG_SENSOR_THR, 16'($urandom_range(64, 2048)));
    write_reg(REG_ALPHA, 16'hFFFF);
    queue_random(20, PROF_MIXED);
    wait_idle();
    write_reg(REG_ALPHA, 16'd0);
    queue_random(10, PROF_MIXED);
    wait_idle();
    write_reg(REG_ALPHA, 16'd1);
    queue_random(10, PROF_MIXED);
    wait_idle();

    // Closing stretch at full rate on both sides
    write_reg(REG_MODE, {14'd0, MODE_THRESHOLD});
    write_reg(REG_FAN_THR, 16'hFFFF);
    write_reg(REG_PUMP_THR, 16'($urandom_range(1000, 30000)));
    write_reg(REG_SENSOR_THR, 16'($urandom_range(64, 2048)));
    calm_tail = 1'b1;
    queue_random(70, PROF_MIXED);
    wait_idle();
    repeat (100) @(posedge clk_i);

    $display("checked %0d score beats, %0d with alarm, %0d mismatches", beats_checked,
             alarms_seen, mismatches);
    $display("samples by mode: threshold %0d, ewma %0d, cusum %0d, unused %0d",
             mode_count[MODE_THRESHOLD], mode_count[MODE_EWMA], mode_count[MODE_CUSUM],
             mode_count[MODE_UNUSED]);
    if (mismatches == 0) begin
      $display("residual_change_detector_top regression: pass");
    end else begin
      $display("residual_change_detector_top regression: fail");
    end
    $finish;
  end

endmodule
